>>> sv/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared constants and types for the debounced push button with long press.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

  // Number of raw samples kept in the debounce history.
  localparam int unsigned HistoryBits = 16;
  localparam int unsigned NowW        = 32;
  localparam int unsigned ThreshW     = 15;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 15;

  // Thresholds below this value select press-only mode.
  localparam logic [ThreshW-1:0] LongModeMin = ThreshW'(500);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegIdleLevel     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegLongThreshold = CfgIdxW'(1);

  typedef logic [HistoryBits-1:0] hist_t;

  typedef struct packed {
    logic               idle_level;
    logic [ThreshW-1:0] long_threshold_ms;
  } cfg_t;

  typedef struct packed {
    logic short_tap;
    logic long_hold;
    logic steady_down;
    logic steady_up;
  } result_t;

endpackage

`default_nettype wire

>>> sv/bdlp_if.sv
// ----------------------------------------------------------------------------
// bdlp_if
// Handshake channels of the push button block: sample input, result output
// and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdlp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         sample;
  logic [bdlp_pkg::NowW-1:0]    now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface bdlp_out_if;
  logic valid;
  logic ready;
  logic short_tap;
  logic long_hold;
  logic steady_down;
  logic steady_up;

  modport source (output valid, output short_tap, output long_hold,
                  output steady_down, output steady_up, input ready);
  modport sink   (input valid, input short_tap, input long_hold,
                  input steady_down, input steady_up, output ready);
endinterface

interface bdlp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bdlp_pkg::CfgIdxW-1:0]    index;
  logic [bdlp_pkg::CfgDataW-1:0]   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> sv/bdlp_cfg.sv
// ----------------------------------------------------------------------------
// bdlp_cfg
// Configuration registers: idle level and long press threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [bdlp_pkg::CfgIdxW-1:0]    wr_index_i,
  input  wire logic [bdlp_pkg::CfgDataW-1:0]   wr_data_i,
  output bdlp_pkg::cfg_t                       cfg_o
);

  bdlp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        bdlp_pkg::RegIdleLevel:     cfg_d.idle_level = wr_data_i[0];
        bdlp_pkg::RegLongThreshold: cfg_d.long_threshold_ms =
                                      wr_data_i[bdlp_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_level        <= 1'b1;
      cfg_q.long_threshold_ms <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/bdlp_core.sv
// ----------------------------------------------------------------------------
// bdlp_core
// Sample history, edge pattern matching and press timing state.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic                         sample_i,
  input  wire logic [bdlp_pkg::NowW-1:0]    now_ms_i,
  input  wire bdlp_pkg::cfg_t               cfg_i,
  output bdlp_pkg::result_t                 result_o
);

  localparam int unsigned HB = bdlp_pkg::HistoryBits;

  bdlp_pkg::hist_t              history_q, history_d;
  logic [bdlp_pkg::NowW-1:0]    press_start_q, press_start_d;
  logic                         pushed_q, pushed_d;
  logic                         released_q, released_d;
  logic                         short_q, short_d;
  logic                         long_q, long_d;

  bdlp_pkg::hist_t              all_pressed, all_idle, press_pat, release_pat;
  logic                         steady_dn, steady_u, press_hit, release_hit;
  logic                         hit, long_mode;
  logic [bdlp_pkg::NowW-1:0]    held;
  logic                         below_thr;

  always_comb begin
    all_pressed = cfg_i.idle_level ? '0 : '1;
    all_idle    = ~all_pressed;
    press_pat   = all_pressed ^ {1'b1, {(HB-1){1'b0}}};
    release_pat = all_pressed ^ {{(HB-1){1'b0}}, 1'b1};

    history_d   = {history_q[HB-2:0], sample_i};
    steady_dn   = (history_d == all_pressed);
    steady_u    = (history_d == all_idle);
    press_hit   = (history_d == press_pat);
    release_hit = (history_d == release_pat);
    long_mode   = (cfg_i.long_threshold_ms >= bdlp_pkg::LongModeMin);

    press_start_d = press_start_q;
    pushed_d      = pushed_q;
    released_d    = released_q;
    short_d       = short_q;
    long_d        = long_q;
    hit           = 1'b0;

    if (press_hit) begin
      press_start_d = now_ms_i;
    end

    if (long_mode) begin
      if (press_hit) begin
        pushed_d   = 1'b1;
        released_d = 1'b0;
        hit        = 1'b1;
      end else if (steady_dn) begin
        hit = 1'b1;
      end else if (release_hit) begin
        released_d = 1'b1;
        hit        = 1'b1;
      end
    end

    // Held time uses the start time as updated by this item.
    held      = now_ms_i - press_start_d;
    below_thr = (held < {{(bdlp_pkg::NowW-bdlp_pkg::ThreshW){1'b0}},
                         cfg_i.long_threshold_ms});

    if (long_mode) begin
      if (hit) begin
        if (pushed_d) begin
          if (below_thr && released_d) begin
            short_d    = 1'b1;
            pushed_d   = 1'b0;
            released_d = 1'b0;
          end else if (!below_thr) begin
            long_d     = 1'b1;
            pushed_d   = 1'b0;
            released_d = 1'b0;
          end
        end
      end else begin
        short_d = 1'b0;
        long_d  = 1'b0;
      end
    end else begin
      if (press_hit) begin
        short_d    = 1'b1;
        pushed_d   = 1'b0;
        released_d = 1'b0;
      end else begin
        short_d = 1'b0;
        long_d  = 1'b0;
      end
    end

    result_o.short_tap   = short_d;
    result_o.long_hold   = long_d;
    result_o.steady_down = steady_dn;
    result_o.steady_up   = steady_u;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      history_q     <= '0;
      press_start_q <= '0;
      pushed_q      <= 1'b0;
      released_q    <= 1'b0;
      short_q       <= 1'b0;
      long_q        <= 1'b0;
    end else if (accept_i) begin
      history_q     <= history_d;
      press_start_q <= press_start_d;
      pushed_q      <= pushed_d;
      released_q    <= released_d;
      short_q       <= short_d;
      long_q        <= long_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Debounced push button with short and long press detection.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_if     sink       sample, now_ms
// out_if    source     short_tap, long_hold, steady_down, steady_up
// cfg_if    sink       index, wdata (0: idle level, 1: long threshold in ms)
//
// One item per cycle: the history shift, pattern match and held-time compare
// are one combinational pass from the state registers into the result
// register, so each result appears in the cycle after its item is accepted.
// A new item is taken whenever the result register is empty or being read.
// Reset clears the history and press state; idle level resets to 1 and the
// threshold to 0. A stalled output holds its result and blocks the input.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bdlp_in_if.sink    in_if,
  bdlp_out_if.source out_if,
  bdlp_cfg_if.sink   cfg_if
);

  bdlp_pkg::cfg_t    cfg;
  bdlp_pkg::result_t result, result_q;
  logic              out_valid_q, out_valid_d;
  logic              in_fire;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = !out_valid_q || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;

  bdlp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_if.valid),
    .wr_index_i (cfg_if.index),
    .wr_data_i  (cfg_if.wdata),
    .cfg_o      (cfg)
  );

  bdlp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .sample_i (in_if.sample),
    .now_ms_i (in_if.now_ms),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.short_tap   = result_q.short_tap;
  assign out_if.long_hold   = result_q.long_hold;
  assign out_if.steady_down = result_q.steady_down;
  assign out_if.steady_up   = result_q.steady_up;

`ifndef SYNTHESIS
  // An empty result register must never hold the input back.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_if.ready)
    else $error("input stalled with an empty result register");

  // Every accepted item produces a result in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_if.valid)
    else $error("accepted item produced no result");

  // The steady patterns are complements, so they cannot match together.
  a_steady_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.steady_down && out_if.steady_up))
    else $error("steady up and steady down reported together");

  // A result that has not been taken stays in place.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |=> (out_valid_q && $stable(result_q)))
    else $error("pending result changed before it was taken");
`endif

endmodule

`default_nettype wire
